// ----- sv/cts_pkg.sv -----
// Shared types, codes and lookup tables of the C token scanner.
`default_nettype none
package cts_pkg;

  localparam int MAX_TEXT_LEN_DEF = 255;
  localparam int LINE_BITS_DEF    = 20;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_IDENT    = 3'd1;
  localparam logic [2:0] MODE_NUMBER   = 3'd2;
  localparam logic [2:0] MODE_STRING   = 3'd3;
  localparam logic [2:0] MODE_CHAR     = 3'd4;
  localparam logic [2:0] MODE_LCOMMENT = 3'd5;
  localparam logic [2:0] MODE_BCOMMENT = 3'd6;
  localparam logic [2:0] MODE_OPERATOR = 3'd7;

  localparam logic [3:0] TK_IDENT   = 4'd0;
  localparam logic [3:0] TK_KEYWORD = 4'd1;
  localparam logic [3:0] TK_INTEGER = 4'd2;
  localparam logic [3:0] TK_REAL    = 4'd3;
  localparam logic [3:0] TK_STRING  = 4'd4;
  localparam logic [3:0] TK_CHAR    = 4'd5;
  localparam logic [3:0] TK_OPER    = 4'd6;
  localparam logic [3:0] TK_ERROR   = 4'd7;
  localparam logic [3:0] TK_EOF     = 4'd8;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd1;
  localparam logic [2:0] ERR_STRING   = 3'd2;
  localparam logic [2:0] ERR_CHAR     = 3'd3;
  localparam logic [2:0] ERR_CHAR_LEN = 3'd4;

  localparam logic [5:0] OP_SLASH     = 6'd4;
  localparam logic [5:0] OP_TILDE     = 6'd9;
  localparam logic [5:0] OP_LAST_PEND = 6'd12;
  localparam logic [5:0] OP_FIRST_TWO = 6'd24;
  localparam logic [5:0] OP_SHL       = 6'd40;
  localparam logic [5:0] OP_SHR       = 6'd41;
  localparam logic [5:0] OP_FIRST_THR = 6'd42;
  localparam logic [5:0] OP_COUNT     = 6'd44;
  localparam logic [5:0] OP_NONE      = 6'd63;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  localparam int KW_COUNT = 37;
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;

  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("double"), 64'("int"), 64'("char"), 64'("BYTE"), 64'("float"),
    64'("short"), 64'("unsigned"), 64'("bool"), 64'("long"), 64'("void"),
    64'("WORD"), 64'("DWORD"), 64'("LONGLONG"), 64'("auto"), 64'("break"),
    64'("struct"), 64'("else"), 64'("switch"), 64'("case"), 64'("enum"),
    64'("register"), 64'("typedef"), 64'("extern"), 64'("return"),
    64'("union"), 64'("const"), 64'("continue"), 64'("for"), 64'("signed"),
    64'("default"), 64'("goto"), 64'("sizeof"), 64'("volatile"), 64'("do"),
    64'("if"), 64'("static"), 64'("while")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd8, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd5, 4'd8, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd8, 4'd7, 4'd6, 4'd6, 4'd5, 4'd5, 4'd8, 4'd3, 4'd6, 4'd7,
    4'd4, 4'd6, 4'd8, 4'd2, 4'd2, 4'd6, 4'd5
  };

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [5:0]  token_code;
    logic [19:0] token_line;
    logic [23:0] token_start;
    logic [7:0]  token_length;
    logic        text_truncated;
    logic [2:0]  error_code;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [5:0]          pend;
    logic [23:0]         pos;
    logic [23:0]         start;
    logic [7:0]          len;
    logic                is_real;
    logic                esc;
    logic [KW_COUNT-1:0] cand;
    logic                ovf;
  } scan_state_t;

  localparam scan_state_t ST_RESET = '{
    mode: MODE_START, pend: OP_NONE, pos: 24'd0, start: 24'd0, len: 8'd0,
    is_real: 1'b0, esc: 1'b0, cand: KW_ALL, ovf: 1'b0
  };

  function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
    logic [3:0] sh;
    sh = KW_LEN[k] - i - 4'd1;
    if (i < KW_LEN[k]) kw_char = KW_TEXT[k][8*sh +: 8];
    else kw_char = 8'd0;
  endfunction

  function automatic token_t mk_tok(input logic [3:0] kind, input logic [5:0] code,
                                    input logic [19:0] line, input logic [23:0] start,
                                    input logic [7:0] len, input logic trunc,
                                    input logic [2:0] err);
    mk_tok = '{token_kind: kind, token_code: code, token_line: line, token_start: start,
               token_length: len, text_truncated: trunc, error_code: err,
               last_of_run: 1'b0};
  endfunction

  function automatic logic [7:0] op_len(input logic [5:0] code);
    if (code < OP_FIRST_TWO) op_len = 8'd1;
    else if (code < OP_FIRST_THR) op_len = 8'd2;
    else op_len = 8'd3;
  endfunction

  // {hit, code}
  function automatic logic [6:0] op_single(input logic [7:0] c);
    case (c)
      8'h3D: op_single = {1'b1, 6'd0};
      8'h2B: op_single = {1'b1, 6'd1};
      8'h2D: op_single = {1'b1, 6'd2};
      8'h2A: op_single = {1'b1, 6'd3};
      8'h2F: op_single = {1'b1, 6'd4};
      8'h25: op_single = {1'b1, 6'd5};
      8'h26: op_single = {1'b1, 6'd6};
      8'h7C: op_single = {1'b1, 6'd7};
      8'h5E: op_single = {1'b1, 6'd8};
      8'h7E: op_single = {1'b1, 6'd9};
      8'h21: op_single = {1'b1, 6'd10};
      8'h3C: op_single = {1'b1, 6'd11};
      8'h3E: op_single = {1'b1, 6'd12};
      8'h3F: op_single = {1'b1, 6'd13};
      8'h28: op_single = {1'b1, 6'd14};
      8'h29: op_single = {1'b1, 6'd15};
      8'h7B: op_single = {1'b1, 6'd16};
      8'h7D: op_single = {1'b1, 6'd17};
      8'h5B: op_single = {1'b1, 6'd18};
      8'h5D: op_single = {1'b1, 6'd19};
      8'h2C: op_single = {1'b1, 6'd20};
      8'h2E: op_single = {1'b1, 6'd21};
      8'h3B: op_single = {1'b1, 6'd22};
      8'h3A: op_single = {1'b1, 6'd23};
      default: op_single = {1'b0, OP_NONE};
    endcase
  endfunction

  // {hit, code}
  function automatic logic [6:0] op_extend(input logic [5:0] p, input logic [7:0] c);
    op_extend = {1'b0, OP_NONE};
    if (c == CH_EQ) begin
      case (p)
        6'd0:  op_extend = {1'b1, 6'd24};
        6'd10: op_extend = {1'b1, 6'd25};
        6'd1:  op_extend = {1'b1, 6'd28};
        6'd2:  op_extend = {1'b1, 6'd29};
        6'd3:  op_extend = {1'b1, 6'd30};
        6'd4:  op_extend = {1'b1, 6'd31};
        6'd5:  op_extend = {1'b1, 6'd32};
        6'd6:  op_extend = {1'b1, 6'd33};
        6'd8:  op_extend = {1'b1, 6'd34};
        6'd7:  op_extend = {1'b1, 6'd35};
        6'd12: op_extend = {1'b1, 6'd36};
        6'd11: op_extend = {1'b1, 6'd37};
        6'd40: op_extend = {1'b1, 6'd42};
        6'd41: op_extend = {1'b1, 6'd43};
        default: op_extend = {1'b0, OP_NONE};
      endcase
    end else if (c == CH_PLUS && p == 6'd1) op_extend = {1'b1, 6'd26};
    else if (c == CH_MINUS && p == 6'd2) op_extend = {1'b1, 6'd27};
    else if (c == CH_AMP && p == 6'd6) op_extend = {1'b1, 6'd38};
    else if (c == CH_BAR && p == 6'd7) op_extend = {1'b1, 6'd39};
    else if (c == CH_LT && p == 6'd11) op_extend = {1'b1, OP_SHL};
    else if (c == CH_GT && p == 6'd12) op_extend = {1'b1, OP_SHR};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cts_if.sv -----
// Channel interfaces: source bytes in, tokens out.
`default_nettype none
interface cts_byte_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] source_byte;
  modport source (output valid, cmd, source_byte, input ready);
  modport sink (input valid, cmd, source_byte, output ready);
endinterface

interface cts_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [5:0]  token_code;
  logic [19:0] token_line;
  logic [23:0] token_start;
  logic [7:0]  token_length;
  logic        text_truncated;
  logic [2:0]  error_code;
  logic        last_of_run;
  modport source (output valid, token_kind, token_code, token_line, token_start,
                  token_length, text_truncated, error_code, last_of_run, input ready);
  modport sink (input valid, token_kind, token_code, token_line, token_start,
                token_length, text_truncated, error_code, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- sv/c_token_scanner_core.sv -----
// Top level of the C token scanner: state registers, transition logic, token queue.
//
//  channel  | dir | handshake     | word
//  in_ch    | in  | valid / ready | cmd, source_byte
//  out_ch   | out | valid / ready | token_kind .. last_of_run
//
// One byte is taken per cycle while input ready is high; the scan state updates at the edge that takes it.
// A byte yields up to two tokens; the queue sends one token per cycle while out_ch ready is high.
// Input ready is low while the queue holds three or more tokens.
// Reset returns the scanner to the start of a source, line 1, offset 0.
`default_nettype none
module c_token_scanner_core #(
  parameter int MAX_TEXT_LEN = cts_pkg::MAX_TEXT_LEN_DEF,
  parameter int LINE_BITS    = cts_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cts_byte_if.sink    in_ch,
  cts_token_if.source out_ch
);
  import cts_pkg::*;

  scan_state_t          st;
  scan_state_t          st_next;
  logic [LINE_BITS-1:0] line;
  logic [LINE_BITS-1:0] line_next;
  token_t               tk0;
  token_t               tk1;
  logic [1:0]           n;
  logic                 space;
  logic                 acc;

  assign in_ch.ready = space;
  assign acc         = in_ch.valid && space;

  cts_step #(.MAX_TEXT_LEN(MAX_TEXT_LEN), .LINE_BITS(LINE_BITS)) u_step (
    .st(st), .line(line), .cmd(in_ch.cmd), .c(in_ch.source_byte),
    .ns(st_next), .nline(line_next), .tk0(tk0), .tk1(tk1), .n(n)
  );

  cts_queue u_queue (
    .clk(clk), .rst(rst), .push_n(acc ? n : 2'd0), .tk0(tk0), .tk1(tk1),
    .space(space), .out_ch(out_ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_RESET;
      line <= LINE_BITS'(1);
    end else if (acc) begin
      st   <= st_next;
      line <= line_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cts_step.sv -----
// Per-byte scanner transition: next state and up to two tokens.
`default_nettype none
module cts_step #(
  parameter int MAX_TEXT_LEN = cts_pkg::MAX_TEXT_LEN_DEF,
  parameter int LINE_BITS    = cts_pkg::LINE_BITS_DEF
) (
  input  cts_pkg::scan_state_t st,
  input  logic [LINE_BITS-1:0] line,
  input  logic                 cmd,
  input  logic [7:0]           c,
  output cts_pkg::scan_state_t ns,
  output logic [LINE_BITS-1:0] nline,
  output cts_pkg::token_t      tk0,
  output cts_pkg::token_t      tk1,
  output logic [1:0]           n
);
  import cts_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_TEXT_LEN);

  logic [LINE_BITS+19:0] line_ext;
  logic [19:0]           tline;
  logic [KW_COUNT-1:0]   filt;
  logic [KW_COUNT-1:0]   first;
  logic [KW_COUNT-1:0]   lenmatch;
  logic                  kw_ok;
  logic [5:0]            kw_code;
  logic [6:0]            sgl;
  logic [6:0]            ext;
  logic                  go;
  token_t                tk [2];

  assign line_ext = {20'd0, line};
  assign tline    = line_ext[19:0];
  assign sgl      = op_single(c);
  assign ext      = op_extend(st.pend, c);

  always_comb begin
    kw_code = 6'd0;
    for (int k = 0; k < KW_COUNT; k++) begin
      filt[k]     = !(st.len >= 8'd8 || st.ovf) && kw_char(k, st.len[3:0]) == c;
      first[k]    = kw_char(k, 4'd0) == c;
      lenmatch[k] = {4'd0, KW_LEN[k]} == st.len;
    end
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (st.cand[k] && lenmatch[k]) kw_code = 6'(k);
    end
    kw_ok = !st.ovf && st.len <= 8'd8 && |(st.cand & lenmatch);
  end

  always_comb begin
    ns    = st;
    nline = line;
    tk[0] = '0;
    tk[1] = '0;
    n     = 2'd0;
    go    = 1'b0;
    if (cmd == CMD_END) begin
      case (st.mode)
        MODE_IDENT: begin
          if (kw_ok) tk[0] = mk_tok(TK_KEYWORD, kw_code, tline, st.start, st.len, 1'b0,
                                    ERR_NONE);
          else tk[0] = mk_tok(TK_IDENT, 6'd0, tline, st.start, st.len, st.ovf, ERR_NONE);
          n = 2'd1;
        end
        MODE_NUMBER: begin
          tk[0] = mk_tok(st.is_real ? TK_REAL : TK_INTEGER, 6'd0, tline, st.start, st.len,
                         1'b0, ERR_NONE);
          n = 2'd1;
        end
        MODE_OPERATOR: begin
          if (st.pend < OP_COUNT) begin
            tk[0] = mk_tok(TK_OPER, st.pend, tline, st.start, op_len(st.pend), 1'b0,
                           ERR_NONE);
            n = 2'd1;
          end
        end
        MODE_STRING: begin
          tk[0] = mk_tok(TK_ERROR, 6'd0, tline, st.start, st.len, 1'b0, ERR_STRING);
          n = 2'd1;
        end
        MODE_CHAR: begin
          tk[0] = mk_tok(TK_ERROR, 6'd0, tline, st.start, st.len, 1'b0, ERR_CHAR);
          n = 2'd1;
        end
        default: ;
      endcase
      tk[n[0]] = mk_tok(TK_EOF, 6'd0, tline, st.pos, 8'd0, 1'b0, ERR_NONE);
      n = n + 2'd1;
      ns = ST_RESET;
      nline = LINE_BITS'(1);
    end else begin
      case (st.mode)
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            ns.cand = st.cand & filt;
            if (st.len < MAX_LEN) ns.len = st.len + 8'd1;
            else begin
              ns.ovf  = 1'b1;
              ns.cand = '0;
            end
          end else begin
            if (kw_ok) tk[0] = mk_tok(TK_KEYWORD, kw_code, tline, st.start, st.len, 1'b0,
                                      ERR_NONE);
            else tk[0] = mk_tok(TK_IDENT, 6'd0, tline, st.start, st.len, st.ovf, ERR_NONE);
            n  = 2'd1;
            go = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c) || c == CH_DOT) begin
            if (c == CH_DOT) ns.is_real = 1'b1;
            if (st.len < MAX_LEN) ns.len = st.len + 8'd1;
            else ns.ovf = 1'b1;
          end else begin
            tk[0] = mk_tok(st.is_real ? TK_REAL : TK_INTEGER, 6'd0, tline, st.start, st.len,
                           1'b0, ERR_NONE);
            n  = 2'd1;
            go = 1'b1;
          end
        end
        MODE_STRING: begin
          if (st.esc || !(c == CH_DQUOT || c == CH_BSL || c == CH_CR || c == CH_LF)) begin
            ns.esc = 1'b0;
            if (st.len < MAX_LEN) ns.len = st.len + 8'd1;
            else ns.ovf = 1'b1;
          end else if (c == CH_DQUOT) begin
            tk[0] = mk_tok(TK_STRING, 6'd0, tline, st.start, st.len, st.ovf, ERR_NONE);
            n = 2'd1;
            ns.mode = MODE_START;
          end else if (c == CH_BSL) begin
            ns.esc = 1'b1;
          end else begin
            tk[0] = mk_tok(TK_ERROR, 6'd0, tline, st.start, st.len, 1'b0, ERR_STRING);
            n = 2'd1;
            ns.mode = MODE_START;
          end
        end
        MODE_CHAR: begin
          if (st.esc || !(c == CH_SQUOT || c == CH_BSL || c == CH_CR || c == CH_LF)) begin
            ns.esc = 1'b0;
            if (st.len >= 8'd1) begin
              tk[0] = mk_tok(TK_ERROR, 6'd0, tline, st.start, st.len, 1'b0, ERR_CHAR_LEN);
              n = 2'd1;
              ns.mode = MODE_START;
            end else begin
              ns.len = 8'd1;
            end
          end else if (c == CH_SQUOT) begin
            tk[0] = mk_tok(TK_CHAR, 6'd0, tline, st.start, st.len, 1'b0, ERR_NONE);
            n = 2'd1;
            ns.mode = MODE_START;
          end else if (c == CH_BSL) begin
            ns.esc = 1'b1;
          end else begin
            tk[0] = mk_tok(TK_ERROR, 6'd0, tline, st.start, st.len, 1'b0, ERR_CHAR);
            n = 2'd1;
            ns.mode = MODE_START;
          end
        end
        MODE_LCOMMENT: begin
          if (c == CH_CR || c == CH_LF) ns.mode = MODE_START;
        end
        MODE_BCOMMENT: begin
          if (c == CH_STAR) ns.esc = 1'b1;
          else begin
            ns.esc = 1'b0;
            if (c == CH_SLASH && st.esc) ns.mode = MODE_START;
          end
        end
        MODE_OPERATOR: begin
          if (st.pend == OP_SLASH && c == CH_SLASH) begin
            ns.mode = MODE_LCOMMENT;
            ns.pend = OP_NONE;
          end else if (st.pend == OP_SLASH && c == CH_STAR) begin
            ns.mode = MODE_BCOMMENT;
            ns.pend = OP_NONE;
            ns.esc  = 1'b0;
          end else if (ext[6]) begin
            if (ext[5:0] == OP_SHL || ext[5:0] == OP_SHR) begin
              ns.pend = ext[5:0];
            end else begin
              tk[0] = mk_tok(TK_OPER, ext[5:0], tline, st.start, op_len(ext[5:0]), 1'b0,
                             ERR_NONE);
              n = 2'd1;
              ns.mode = MODE_START;
              ns.pend = OP_NONE;
            end
          end else begin
            tk[0] = mk_tok(TK_OPER, st.pend, tline, st.start, op_len(st.pend), 1'b0,
                           ERR_NONE);
            n  = 2'd1;
            go = 1'b1;
          end
        end
        default: go = 1'b1;
      endcase

      if (go) begin
        ns         = ST_RESET;
        ns.pos     = st.pos;
        ns.start   = st.pos;
        if (is_digit(c) || c == CH_DOT) begin
          ns.mode    = MODE_NUMBER;
          ns.len     = 8'd1;
          ns.is_real = c == CH_DOT;
        end else if (is_alpha(c)) begin
          ns.mode = MODE_IDENT;
          ns.cand = first;
          ns.len  = 8'd1;
        end else if (c == CH_DQUOT) begin
          ns.mode = MODE_STRING;
        end else if (c == CH_SQUOT) begin
          ns.mode = MODE_CHAR;
        end else if (is_space(c)) begin
          ns.mode = MODE_START;
        end else if (sgl[6]) begin
          if (sgl[5:0] <= OP_LAST_PEND && sgl[5:0] != OP_TILDE) begin
            ns.mode = MODE_OPERATOR;
            ns.pend = sgl[5:0];
          end else begin
            tk[n[0]] = mk_tok(TK_OPER, sgl[5:0], tline, st.pos, 8'd1, 1'b0, ERR_NONE);
            n = n + 2'd1;
          end
        end else begin
          tk[n[0]] = mk_tok(TK_ERROR, 6'd0, tline, st.pos, 8'd1, 1'b0, ERR_UNKNOWN);
          n = n + 2'd1;
        end
      end

      if (c == CH_LF && line != '1) nline = line + LINE_BITS'(1);
      ns.pos = st.pos + 24'd1;
    end
    if (n != 2'd0) tk[n[1]].last_of_run = 1'b1;
  end

  assign tk0 = tk[0];
  assign tk1 = tk[1];

endmodule
`default_nettype wire

// ----- sv/cts_queue.sv -----
// Four-word token queue that takes up to two tokens a cycle and sends one while out_ch ready is high.
`default_nettype none
module cts_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  cts_pkg::token_t     tk0,
  input  cts_pkg::token_t     tk1,
  output logic                space,
  cts_token_if.source         out_ch
);
  import cts_pkg::*;

  token_t     mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       pop;
  token_t     head;

  assign pop   = out_ch.valid && out_ch.ready;
  assign space = cnt <= 3'd2;
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      wp  <= wp + push_n;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {1'b0, push_n} - {2'd0, pop};
    end
    if (push_n != 2'd0) mem[wp] <= tk0;
    if (push_n == 2'd2) mem[wp + 2'd1] <= tk1;
  end

  assign out_ch.valid          = cnt != 3'd0;
  assign out_ch.token_kind     = head.token_kind;
  assign out_ch.token_code     = head.token_code;
  assign out_ch.token_line     = head.token_line;
  assign out_ch.token_start    = head.token_start;
  assign out_ch.token_length   = head.token_length;
  assign out_ch.text_truncated = head.text_truncated;
  assign out_ch.error_code     = head.error_code;
  assign out_ch.last_of_run    = head.last_of_run;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("queue count overflow");
  a_push_space: assert property (@(posedge clk) disable iff (rst) push_n != 2'd0 |-> space)
    else $error("push without room");
  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    !pop |=> cnt == 3'($past(cnt) + {1'b0, $past(push_n)}))
    else $error("queue count mismatch");
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.token_kind == TK_EOF |-> out_ch.last_of_run)
    else $error("eof token not last of run");
`endif

endmodule
`default_nettype wire
